### hdl/tbsa_pkg.sv
// Package for the typed byte stack ALU: operation and error codes, widths.
// No dependencies.
package tbsa_pkg;

  localparam int unsigned StackBytesDefault = 256;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned DepthWidth = 9;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0,
    OP_ADD  = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_DIV  = 4'd4,
    OP_MOD  = 4'd5,
    OP_OR   = 4'd6,
    OP_AND  = 4'd7,
    OP_EQU  = 4'd8,
    OP_DUP  = 4'd9,
    OP_DROP = 4'd10,
    OP_SWAP = 4'd11,
    OP_RSV0 = 4'd12,
    OP_RSV1 = 4'd13,
    OP_RSV2 = 4'd14,
    OP_RSV3 = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_e;

  typedef struct packed {
    logic [3:0]            operation;
    logic                  wide;
    logic [ValueWidth-1:0] literal;
  } req_t;

  typedef struct packed {
    logic [ValueWidth-1:0] top_value;
    logic [DepthWidth-1:0] depth_bytes;
    logic [1:0]            error;
  } rsp_t;

endpackage

### hdl/tbsa_if.sv
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; the payload type is a parameter.
interface tbsa_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hdl/typed_byte_stack_alu.sv
// Byte-addressed stack ALU working at 8 or 64 bits per word.
// Depends on tbsa_pkg and tbsa_if.
// Stack bytes move one at a time: reads go through the registered memory read, writes go
// straight to the memory, and mul/div/mod take one bit per cycle in a shared adder (64
// steps wide, 8 steps narrow). The states run check, load b, load a, execute, iterate,
// store, store b, top read and done, as the operation needs them.
// One word at a time: a new request is taken in the cycle after the response is taken.
// Reset empties the stack; the byte memory is not cleared.
module typed_byte_stack_alu #(
  parameter int unsigned STACK_BYTES = tbsa_pkg::StackBytesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  tbsa_if.sink   req_i,
  tbsa_if.source rsp_o
);
  import tbsa_pkg::*;

  localparam int unsigned AddrW = $clog2(STACK_BYTES);
  localparam int unsigned SpW   = $clog2(STACK_BYTES + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CHECK = 10'b0000000010,
    S_LOADB = 10'b0000000100,
    S_LOADA = 10'b0000001000,
    S_EXEC  = 10'b0000010000,
    S_ITER  = 10'b0000100000,
    S_STORE = 10'b0001000000,
    S_STORB = 10'b0010000000,
    S_TOP   = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0] mem_q [STACK_BYTES];
  logic [7:0] rdata_q;

  op_e                   op_q;
  logic                  wide_q;
  logic [ValueWidth-1:0] lit_q, a_q, b_q, r_q, acc_q, sh_q;
  logic [SpW-1:0]        sp_q;
  logic [2:0]            cnt_q;
  logic                  rd_pend_q;
  logic [6:0]            step_q;
  err_e                  err_q;
  logic                  out_valid_q;

  logic [SpW:0]          w_x, w2_x, sp_x, cap_x, need_x, base_x, addr_x;
  logic [2:0]            last_byte;
  logic [5:0]            bit_ofs;
  logic [ValueWidth-1:0] mask;
  logic                  is_bin, under_x, over_x, last_cnt, last_rd, divz;
  logic                  mem_we;
  logic [7:0]            mem_wd;
  logic [ValueWidth:0]   alu_x, alu_y, alu_s;
  logic                  alu_ci;
  logic [ValueWidth-1:0] acc_nx;
  logic                  q_bit;

  assign w_x       = wide_q ? (SpW+1)'(8) : (SpW+1)'(1);
  assign w2_x      = w_x << 1;
  assign sp_x      = {1'b0, sp_q};
  assign cap_x     = (SpW+1)'(STACK_BYTES);
  assign last_byte = wide_q ? 3'd7 : 3'd0;
  assign bit_ofs   = {cnt_q, 3'b000};
  assign mask      = wide_q ? '1 : ValueWidth'(8'hFF);
  assign is_bin    = (op_q >= OP_ADD) && (op_q <= OP_EQU);
  assign last_cnt  = (cnt_q == last_byte);
  assign last_rd   = rd_pend_q && last_cnt;
  assign divz      = (op_q == OP_DIV || op_q == OP_MOD) && (b_q == '0);

  // Bytes that the operation must find on the stack.
  always_comb begin
    unique case (op_q) inside
      OP_DUP, OP_DROP: need_x = w_x;
      OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND, OP_EQU:
        need_x = w2_x;
      default: need_x = '0;
    endcase
  end

  assign under_x = (sp_x < need_x);
  assign over_x  = (op_q == OP_PUSH || op_q == OP_DUP) && (sp_x + w_x > cap_x);

  // Byte address base for the current transfer.
  always_comb begin
    unique case (state_q)
      S_LOADB, S_STORB, S_TOP: base_x = sp_x - w_x;
      S_LOADA:                 base_x = sp_x - w2_x;
      S_STORE:                 base_x = (op_q == OP_PUSH || op_q == OP_DUP) ? sp_x :
                                        sp_x - w2_x;
      default:                 base_x = '0;
    endcase
  end

  assign addr_x = base_x + (SpW+1)'(cnt_q);
  assign mem_we = (state_q == S_STORE) || (state_q == S_STORB);
  assign mem_wd = (state_q == S_STORB) ? a_q[bit_ofs +: 8] : r_q[bit_ofs +: 8];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[addr_x[AddrW-1:0]] <= mem_wd;
    rdata_q <= mem_q[addr_x[AddrW-1:0]];
  end

  // Shared adder: add and sub in one pass, one multiply or divide bit per cycle.
  always_comb begin
    alu_x  = {1'b0, a_q};
    alu_y  = {1'b0, b_q};
    alu_ci = 1'b0;
    if (state_q == S_ITER && op_q == OP_MUL) begin
      alu_x = {1'b0, r_q[ValueWidth-2:0], 1'b0};
      alu_y = sh_q[ValueWidth-1] ? {1'b0, b_q} : '0;
    end else if (state_q == S_ITER) begin
      alu_x  = {acc_q, sh_q[ValueWidth-1]};
      alu_y  = ~{1'b0, b_q};
      alu_ci = 1'b1;
    end else if (op_q == OP_SUB) begin
      alu_y  = ~{1'b0, b_q};
      alu_ci = 1'b1;
    end
  end

  assign alu_s = alu_x + alu_y + {{ValueWidth{1'b0}}, alu_ci};
  // The top bit is the borrow of the trial subtraction.
  assign q_bit  = !alu_s[ValueWidth];
  assign acc_nx = alu_s[ValueWidth] ? {acc_q[ValueWidth-2:0], sh_q[ValueWidth-1]} :
                                      alu_s[ValueWidth-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req_i.valid) state_d = S_CHECK;
      S_CHECK: begin
        if (under_x || over_x) state_d = S_TOP;
        else begin
          unique case (op_q) inside
            OP_PUSH: state_d = S_STORE;
            OP_DUP, OP_SWAP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND,
            OP_EQU: state_d = S_LOADB;
            default: state_d = S_TOP;
          endcase
        end
      end
      S_LOADB: if (last_rd) state_d = (op_q == OP_DUP) ? S_STORE : S_LOADA;
      S_LOADA: if (last_rd) state_d = (op_q == OP_SWAP) ? S_STORE : S_EXEC;
      S_EXEC: begin
        if (divz) state_d = S_TOP;
        else if (op_q == OP_MUL || op_q == OP_DIV || op_q == OP_MOD) state_d = S_ITER;
        else state_d = S_STORE;
      end
      S_ITER:  if (step_q == 7'd1) state_d = S_STORE;
      S_STORE: if (last_cnt) state_d = (op_q == OP_SWAP) ? S_STORB : S_TOP;
      S_STORB: if (last_cnt) state_d = S_TOP;
      S_TOP:   if (sp_x < w_x || last_rd) state_d = S_DONE;
      S_DONE:  if (rsp_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_PUSH;
      wide_q      <= 1'b0;
      lit_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      r_q         <= '0;
      acc_q       <= '0;
      sh_q        <= '0;
      sp_q        <= '0;
      cnt_q       <= '0;
      rd_pend_q   <= 1'b0;
      step_q      <= '0;
      err_q       <= ERR_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (state_d == S_DONE);
      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q      <= op_e'(req_i.payload.operation);
            wide_q    <= req_i.payload.wide;
            lit_q     <= req_i.payload.literal;
            err_q     <= ERR_OK;
            cnt_q     <= '0;
            rd_pend_q <= 1'b0;
          end
        end
        S_CHECK: begin
          a_q <= '0;
          b_q <= '0;
          r_q <= lit_q & mask;
          if (under_x) err_q <= ERR_UNDER;
          else if (over_x) err_q <= ERR_OVER;
          else if (op_q == OP_DROP) sp_q <= sp_q - SpW'(w_x);
        end
        S_LOADB, S_LOADA, S_TOP: begin
          if (state_q == S_TOP && sp_x < w_x) begin
            r_q <= '0;
          end else if (rd_pend_q) begin
            if (state_q == S_LOADB) begin
              b_q[bit_ofs +: 8] <= rdata_q;
              r_q[bit_ofs +: 8] <= rdata_q;
            end else if (state_q == S_LOADA) begin
              a_q[bit_ofs +: 8] <= rdata_q;
            end else begin
              r_q[bit_ofs +: 8] <= rdata_q;
            end
            rd_pend_q <= 1'b0;
            cnt_q     <= last_cnt ? 3'd0 : cnt_q + 3'd1;
          end else begin
            rd_pend_q <= 1'b1;
            if (state_q == S_TOP && cnt_q == 3'd0) r_q <= '0;
          end
        end
        S_EXEC: begin
          acc_q  <= '0;
          // The multiplier or dividend shifts out of the top, narrow words included.
          sh_q   <= wide_q ? a_q : {a_q[7:0], 56'd0};
          step_q <= wide_q ? 7'd64 : 7'd8;
          unique case (op_q) inside
            OP_ADD, OP_SUB: r_q <= alu_s[ValueWidth-1:0] & mask;
            OP_OR:  r_q <= ValueWidth'(a_q != '0 || b_q != '0);
            OP_AND: r_q <= ValueWidth'(a_q != '0 && b_q != '0);
            OP_EQU: r_q <= ValueWidth'(a_q == b_q);
            default: r_q <= '0;
          endcase
          if (divz) err_q <= ERR_DIVZ;
        end
        S_ITER: begin
          step_q <= step_q - 7'd1;
          sh_q   <= sh_q << 1;
          if (op_q == OP_MUL) begin
            r_q <= alu_s[ValueWidth-1:0] & mask;
          end else begin
            acc_q <= acc_nx;
            if (op_q == OP_MOD && step_q == 7'd1) r_q <= acc_nx;
            else r_q <= {r_q[ValueWidth-2:0], q_bit};
          end
        end
        S_STORE, S_STORB: begin
          cnt_q <= last_cnt ? 3'd0 : cnt_q + 3'd1;
          if (state_q == S_STORE && last_cnt) begin
            if (op_q == OP_PUSH || op_q == OP_DUP) sp_q <= sp_q + SpW'(w_x);
            else if (is_bin) sp_q <= sp_q - SpW'(w_x);
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp_o.valid               = out_valid_q;
  assign rsp_o.payload.top_value   = r_q & mask;
  assign rsp_o.payload.depth_bytes = DepthWidth'(sp_q);
  assign rsp_o.payload.error       = err_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> state_q == S_DONE)
    else $error("response valid outside done state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_x <= (SpW+1)'(STACK_BYTES))
    else $error("stack pointer beyond capacity");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("accepted a word while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> (rsp_o.valid && $stable(rsp_o.payload)))
    else $error("response word changed while waiting");
endmodule
